// ===== hdl/key_chord_remapper_core_macros.svh =====
// Assertion macros used by the file that checks this block.
`ifndef KEY_CHORD_REMAPPER_CORE_MACROS_SVH
`define KEY_CHORD_REMAPPER_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define KCR_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("kcr: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define KCR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("kcr: next-cycle check failed");

`endif

// ===== hdl/kcr_pkg.sv =====
package kcr_pkg;

	localparam int PENDING_MAX = 255;
	localparam int PENDING_W = $clog2(PENDING_MAX + 1);
	localparam int MAX_RESULTS = 3;
	localparam int CNT_W = $clog2(MAX_RESULTS + 1);
	localparam int QDEPTH = 2;
	localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W = $clog2(QDEPTH + 1);
	localparam int IDX_W = 3;

	typedef logic [PENDING_W-1:0] pend_t;
	typedef logic [CNT_W-1:0] rcnt_t;

	typedef enum logic [IDX_W-1:0] {
		REG_LEFT_WIN     = 3'd0,
		REG_RIGHT_WIN    = 3'd1,
		REG_LEFT_SHIFT   = 3'd2,
		REG_RIGHT_SHIFT  = 3'd3,
		REG_RIGHT_CTRL   = 3'd4,
		REG_TRIGGER      = 3'd5,
		REG_TRIG_PREFIX  = 3'd6
	} reg_index_t;

	localparam logic [7:0] RST_LEFT_WIN    = 8'd91;
	localparam logic [7:0] RST_RIGHT_WIN   = 8'd92;
	localparam logic [7:0] RST_LEFT_SHIFT  = 8'd42;
	localparam logic [7:0] RST_RIGHT_SHIFT = 8'd54;
	localparam logic [7:0] RST_RIGHT_CTRL  = 8'd29;
	localparam logic [7:0] RST_TRIGGER     = 8'd110;

	typedef struct packed {
		logic [7:0] unit_id;
		logic [7:0] scan_code;
		logic       prefix_e0;
		logic       key_release;
		logic [5:0] other_flags;
	} result_t;

	typedef struct packed {
		rcnt_t                         count;
		result_t [MAX_RESULTS-1:0]     res;
	} batch_t;

	typedef struct packed {
		logic armed;
		logic chord_active;
		logic release_phase;
	} status_t;

endpackage

// ===== hdl/kcr_in_if.sv =====
interface kcr_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] unit_id;
	logic [7:0] scan_code;
	logic       prefix_e0;
	logic       key_release;
	logic [5:0] other_flags;

	modport source (output valid, unit_id, scan_code, prefix_e0, key_release, other_flags,
		input ready);
	modport sink (input valid, unit_id, scan_code, prefix_e0, key_release, other_flags,
		output ready);
endinterface

// ===== hdl/kcr_out_if.sv =====
interface kcr_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_unit_id;
	logic [7:0] out_scan_code;
	logic       out_prefix_e0;
	logic       out_key_release;
	logic [5:0] out_other_flags;
	logic       last_of_run;

	modport source (output valid, out_unit_id, out_scan_code, out_prefix_e0,
		out_key_release, out_other_flags, last_of_run, input ready);
	modport sink (input valid, out_unit_id, out_scan_code, out_prefix_e0,
		out_key_release, out_other_flags, last_of_run, output ready);
endinterface

// ===== hdl/kcr_front.sv =====
module kcr_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  logic [kcr_pkg::IDX_W-1:0] wr_index,
	input  logic [7:0]           wr_data,
	kcr_in_if.sink               key_event,
	output logic                 push_valid,
	input  logic                 push_ready,
	output kcr_pkg::batch_t      push_batch,
	output kcr_pkg::status_t     status
);

	logic [7:0] left_win_q, right_win_q, left_shift_q, right_shift_q;
	logic [7:0] right_ctrl_q, trigger_q;
	logic       trig_prefix_q;

	logic       armed_q, snapshot_q, shift_down_q, chord_q, release_q;
	logic [7:0] armed_unit_q;
	kcr_pkg::pend_t lshift_q, rshift_q, lwin_q, rwin_q;

	logic       armed_d, snapshot_d, shift_down_d, chord_d, release_d;
	logic [7:0] armed_unit_d;
	kcr_pkg::pend_t lshift_d, rshift_d, lwin_d, rwin_d;

	logic accept, make, is_shift, is_win, is_trig, forward;
	kcr_pkg::result_t in_res;
	kcr_pkg::batch_t  batch;

	function automatic kcr_pkg::result_t synth(input logic [7:0] unit, input logic [7:0] sc,
		input logic e0, input logic rel);
		kcr_pkg::result_t r;
		r.unit_id     = unit;
		r.scan_code   = sc;
		r.prefix_e0   = e0;
		r.key_release = rel;
		r.other_flags = 6'd0;
		return r;
	endfunction

	function automatic kcr_pkg::pend_t bump(input kcr_pkg::pend_t c);
		if (c != kcr_pkg::PENDING_W'(kcr_pkg::PENDING_MAX))
			return c + kcr_pkg::PENDING_W'(1);
		return c;
	endfunction

	assign key_event.ready = push_ready;
	assign accept = key_event.valid && push_ready;

	assign make     = !key_event.key_release;
	assign is_shift = !key_event.prefix_e0 &&
		(key_event.scan_code == left_shift_q || key_event.scan_code == right_shift_q);
	assign is_win   = key_event.prefix_e0 &&
		(key_event.scan_code == left_win_q || key_event.scan_code == right_win_q);
	assign is_trig  = (key_event.scan_code == trigger_q) && (key_event.prefix_e0 == trig_prefix_q);

	always_comb begin
		in_res.unit_id     = key_event.unit_id;
		in_res.scan_code   = key_event.scan_code;
		in_res.prefix_e0   = key_event.prefix_e0;
		in_res.key_release = key_event.key_release;
		in_res.other_flags = key_event.other_flags;
	end

	always_comb begin
		armed_d      = armed_q;
		armed_unit_d = armed_unit_q;
		snapshot_d   = snapshot_q;
		shift_down_d = shift_down_q;
		chord_d      = chord_q;
		release_d    = release_q;
		lshift_d     = lshift_q;
		rshift_d     = rshift_q;
		lwin_d       = lwin_q;
		rwin_d       = rwin_q;
		forward      = 1'b1;
		batch.count  = '0;
		batch.res    = '0;

		if (release_q) begin
			if (!make) begin
				if (is_shift) begin
					if (key_event.scan_code == left_shift_q && lshift_q != '0) begin
						lshift_d = lshift_q - kcr_pkg::PENDING_W'(1);
						forward  = 1'b0;
					end else if (key_event.scan_code == right_shift_q && rshift_q != '0) begin
						rshift_d = rshift_q - kcr_pkg::PENDING_W'(1);
						forward  = 1'b0;
					end
				end else if (is_win) begin
					if (key_event.scan_code == left_win_q && lwin_q != '0) begin
						lwin_d  = lwin_q - kcr_pkg::PENDING_W'(1);
						forward = 1'b0;
					end else if (key_event.scan_code == right_win_q && rwin_q != '0) begin
						rwin_d  = rwin_q - kcr_pkg::PENDING_W'(1);
						forward = 1'b0;
					end
				end
			end
			if (lshift_d == '0 && rshift_d == '0 && lwin_d == '0 && rwin_d == '0)
				release_d = 1'b0;
		end else if (chord_q) begin
			if (is_win) begin
				forward = 1'b0;
			end else if (is_trig && !make) begin
				batch.res[0] = synth(key_event.unit_id, right_ctrl_q, 1'b1, 1'b1);
				batch.count  = kcr_pkg::CNT_W'(1);
				chord_d      = 1'b0;
				release_d    = 1'b1;
				forward      = 1'b0;
			end
		end else if (!armed_q) begin
			if (make && is_win && key_event.scan_code == left_win_q) begin
				armed_d      = 1'b1;
				armed_unit_d = key_event.unit_id;
				snapshot_d   = shift_down_q;
				forward      = 1'b0;
			end else if (make && is_trig) begin
				batch.res[0] = synth(key_event.unit_id, left_win_q, 1'b1, 1'b1);
				batch.res[1] = synth(key_event.unit_id, left_shift_q, 1'b0, 1'b1);
				batch.res[2] = synth(key_event.unit_id, right_ctrl_q, 1'b1, 1'b0);
				batch.count  = kcr_pkg::CNT_W'(3);
				lwin_d       = bump(lwin_q);
				lshift_d     = bump(lshift_q);
				shift_down_d = 1'b0;
				chord_d      = 1'b1;
				forward      = 1'b0;
			end
		end else begin
			if (make && is_shift && key_event.scan_code == left_shift_q) begin
				forward = 1'b0;
			end else if (make && is_trig) begin
				batch.res[0] = synth(armed_unit_q, left_win_q, 1'b1, 1'b1);
				if (!snapshot_q) begin
					batch.res[1] = synth(armed_unit_q, left_shift_q, 1'b0, 1'b1);
					batch.res[2] = synth(armed_unit_q, right_ctrl_q, 1'b1, 1'b0);
					batch.count  = kcr_pkg::CNT_W'(3);
					shift_down_d = 1'b0;
				end else begin
					batch.res[1] = synth(armed_unit_q, right_ctrl_q, 1'b1, 1'b0);
					batch.count  = kcr_pkg::CNT_W'(2);
				end
				lwin_d   = bump(lwin_q);
				lshift_d = bump(lshift_q);
				chord_d  = 1'b1;
				armed_d  = 1'b0;
				forward  = 1'b0;
			end else if (!make && is_win && key_event.scan_code == left_win_q) begin
				batch.res[0] = synth(armed_unit_q, left_win_q, 1'b1, 1'b0);
				batch.res[1] = in_res;
				batch.count  = kcr_pkg::CNT_W'(2);
				armed_d      = 1'b0;
				forward      = 1'b0;
			end
		end

		if (forward) begin
			batch.res[0] = in_res;
			batch.count  = kcr_pkg::CNT_W'(1);
			if (is_shift)
				shift_down_d = make;
		end
	end

	assign push_valid = accept && (batch.count != '0);
	assign push_batch = batch;

	assign status.armed         = armed_q;
	assign status.chord_active  = chord_q;
	assign status.release_phase = release_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_win_q    <= kcr_pkg::RST_LEFT_WIN;
			right_win_q   <= kcr_pkg::RST_RIGHT_WIN;
			left_shift_q  <= kcr_pkg::RST_LEFT_SHIFT;
			right_shift_q <= kcr_pkg::RST_RIGHT_SHIFT;
			right_ctrl_q  <= kcr_pkg::RST_RIGHT_CTRL;
			trigger_q     <= kcr_pkg::RST_TRIGGER;
			trig_prefix_q <= 1'b0;
			armed_q       <= 1'b0;
			armed_unit_q  <= 8'd0;
			snapshot_q    <= 1'b0;
			shift_down_q  <= 1'b0;
			chord_q       <= 1'b0;
			release_q     <= 1'b0;
			lshift_q      <= '0;
			rshift_q      <= '0;
			lwin_q        <= '0;
			rwin_q        <= '0;
		end else begin
			if (wr_en) begin
				unique case (wr_index)
					kcr_pkg::REG_LEFT_WIN:    left_win_q    <= wr_data;
					kcr_pkg::REG_RIGHT_WIN:   right_win_q   <= wr_data;
					kcr_pkg::REG_LEFT_SHIFT:  left_shift_q  <= wr_data;
					kcr_pkg::REG_RIGHT_SHIFT: right_shift_q <= wr_data;
					kcr_pkg::REG_RIGHT_CTRL:  right_ctrl_q  <= wr_data;
					kcr_pkg::REG_TRIGGER:     trigger_q     <= wr_data;
					kcr_pkg::REG_TRIG_PREFIX: trig_prefix_q <= wr_data[0];
					default: ;
				endcase
			end
			if (accept) begin
				armed_q      <= armed_d;
				armed_unit_q <= armed_unit_d;
				snapshot_q   <= snapshot_d;
				shift_down_q <= shift_down_d;
				chord_q      <= chord_d;
				release_q    <= release_d;
				lshift_q     <= lshift_d;
				rshift_q     <= rshift_d;
				lwin_q       <= lwin_d;
				rwin_q       <= rwin_d;
			end
		end
	end

endmodule

// ===== hdl/kcr_queue.sv =====
module kcr_queue (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push_valid,
	output logic                       push_ready,
	input  kcr_pkg::batch_t            push_batch,
	output logic                       pop_valid,
	input  logic                       pop_ready,
	output kcr_pkg::batch_t            pop_batch,
	output logic [kcr_pkg::QCNT_W-1:0] fill
);

	kcr_pkg::batch_t mem_q [kcr_pkg::QDEPTH];
	logic [kcr_pkg::QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [kcr_pkg::QCNT_W-1:0] count_q;
	logic do_push, do_pop;

	function automatic logic [kcr_pkg::QPTR_W-1:0] next_ptr(
		input logic [kcr_pkg::QPTR_W-1:0] p);
		if (p == kcr_pkg::QPTR_W'(kcr_pkg::QDEPTH - 1))
			return '0;
		return p + kcr_pkg::QPTR_W'(1);
	endfunction

	assign push_ready = (count_q != kcr_pkg::QCNT_W'(kcr_pkg::QDEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_batch  = mem_q[rd_ptr_q];
	assign fill       = count_q;
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= push_batch;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= next_ptr(wr_ptr_q);
			if (do_pop)
				rd_ptr_q <= next_ptr(rd_ptr_q);
			if (do_push && !do_pop)
				count_q <= count_q + kcr_pkg::QCNT_W'(1);
			else if (do_pop && !do_push)
				count_q <= count_q - kcr_pkg::QCNT_W'(1);
		end
	end

endmodule

// ===== hdl/kcr_back.sv =====
module kcr_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            pop_valid,
	output logic            pop_ready,
	input  kcr_pkg::batch_t pop_batch,
	kcr_out_if.source       key_result
);

	logic            valid_q;
	kcr_pkg::result_t res_q;
	logic            last_q;
	kcr_pkg::rcnt_t  idx_q;
	logic            advance, is_last;
	kcr_pkg::result_t sel;

	assign advance   = !valid_q || key_result.ready;
	assign is_last   = (idx_q == pop_batch.count - kcr_pkg::CNT_W'(1));
	assign pop_ready = advance && is_last;

	always_comb begin
		sel = pop_batch.res[0];
		for (int i = 1; i < kcr_pkg::MAX_RESULTS; i++) begin
			if (idx_q == kcr_pkg::CNT_W'(i))
				sel = pop_batch.res[i];
		end
	end

	always_ff @(posedge clk) begin
		if (advance && pop_valid) begin
			res_q  <= sel;
			last_q <= is_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else if (advance) begin
			valid_q <= pop_valid;
			if (pop_valid) begin
				if (is_last)
					idx_q <= '0;
				else
					idx_q <= idx_q + kcr_pkg::CNT_W'(1);
			end
		end
	end

	assign key_result.valid           = valid_q;
	assign key_result.out_unit_id     = res_q.unit_id;
	assign key_result.out_scan_code   = res_q.scan_code;
	assign key_result.out_prefix_e0   = res_q.prefix_e0;
	assign key_result.out_key_release = res_q.key_release;
	assign key_result.out_other_flags = res_q.other_flags;
	assign key_result.last_of_run     = last_q;

endmodule

// ===== hdl/key_chord_remapper_core.sv =====
// Remaps a left-Win, left-Shift and trigger-key chord into a right-Ctrl press and
// release, swallowing the real breaks of the chord keys afterwards. The front end
// takes one scan event per cycle while the queue has room and settles all chord state
// in that cycle; each event becomes a word group of zero to three result words, which
// waits in a two-entry queue. The back end sends one result word per cycle while the
// result port is ready, through a registered output. A forwarded event or a chord's
// trigger break yields one word, a chord trigger two or three, an armed Win release
// two. The result port sets the sustained rate; the input stalls only when both queue
// entries are taken. The code registers may be written at any time the block is idle.
`include "key_chord_remapper_core_macros.svh"

module key_chord_remapper_core (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      wr_en,
	input  logic [kcr_pkg::IDX_W-1:0] wr_index,
	input  logic [7:0]                wr_data,
	kcr_in_if.sink                    key_event,
	kcr_out_if.source                 key_result
);

	logic                       push_valid, push_ready, pop_valid, pop_ready;
	kcr_pkg::batch_t            push_batch, pop_batch;
	kcr_pkg::status_t           status;
	logic [kcr_pkg::QCNT_W-1:0] fill;

	kcr_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr_en      (wr_en),
		.wr_index   (wr_index),
		.wr_data    (wr_data),
		.key_event  (key_event),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_batch (push_batch),
		.status     (status)
	);

	kcr_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_batch (push_batch),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_batch  (pop_batch),
		.fill       (fill)
	);

	kcr_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_batch  (pop_batch),
		.key_result (key_result)
	);

	`KCR_ASSERT_SAME(a_modes_exclusive, clk, arst_n, 1'b1, $onehot0({status.armed, status.chord_active, status.release_phase}))
	`KCR_ASSERT_SAME(a_fill_bound, clk, arst_n, 1'b1, fill <= kcr_pkg::QCNT_W'(kcr_pkg::QDEPTH))
	`KCR_ASSERT_NEXT(a_stall_no_drain, clk, arst_n, key_result.valid && !key_result.ready, fill >= $past(fill))

endmodule
